// ===== rtl/touch_gesture_classifier_defines.svh =====
// ----------------------------------------------------------------------------
// Touch gesture classifier assertion macros
// Shared property forms for the checker.
// ----------------------------------------------------------------------------
`ifndef TOUCH_GESTURE_CLASSIFIER_DEFINES_SVH
`define TOUCH_GESTURE_CLASSIFIER_DEFINES_SVH

// same-cycle implication, off during reset
`define TGC_ASSERT_NOW(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("%m: label failed");

// next-cycle implication, off during reset
`define TGC_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("%m: label failed");

`endif

// ===== rtl/tgc_pkg.sv =====
// ----------------------------------------------------------------------------
// Touch gesture classifier package
// Widths, register codes, reset values and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tgc_pkg;

  localparam int COORD_BITS   = 10;
  localparam int TICK_BITS    = 11;
  localparam int THRESH_BITS  = 10;
  localparam int HOLD_BITS    = 10;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_VAL_BITS = 10;
  localparam int CMP_BITS     = (COORD_BITS > THRESH_BITS) ? COORD_BITS : THRESH_BITS;

  localparam logic [CFG_IDX_BITS-1:0] CFG_WAIT_FOR_RELEASE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SWIPE_THRESHOLD  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD_TICKS       = 2'd2;

  localparam logic                   RST_WAIT_FOR_RELEASE = 1'b1;
  localparam logic [THRESH_BITS-1:0] RST_SWIPE_THRESHOLD  = THRESH_BITS'(50);
  localparam logic [HOLD_BITS-1:0]   RST_HOLD_TICKS       = HOLD_BITS'(50);

  localparam logic [TICK_BITS-1:0] TICKS_MAX = '1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [TICK_BITS-1:0]  ticks_t;

  typedef struct packed {
    logic                   wait_for_release;
    logic [THRESH_BITS-1:0] swipe_threshold;
    logic [HOLD_BITS-1:0]   hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic   touch_active;
    coord_t pos_x;
    coord_t pos_y;
  } sample_t;

  typedef struct packed {
    logic gesture_done;
    logic click;
    logic hold;
    logic swipe_horizontal;
    logic swipe_vertical;
    logic vibrate;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/tgc_in_if.sv =====
// ----------------------------------------------------------------------------
// Touch sample channel
// Valid/ready channel carrying one touch-panel sample per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tgc_in_if;
  logic            valid;
  logic            ready;
  logic            touch_active;
  tgc_pkg::coord_t pos_x;
  tgc_pkg::coord_t pos_y;

  modport source (output valid, output touch_active, output pos_x, output pos_y,
                  input ready);
  modport sink (input valid, input touch_active, input pos_x, input pos_y,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/tgc_out_if.sv =====
// ----------------------------------------------------------------------------
// Gesture result channel
// Valid/ready channel carrying one classification result per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tgc_out_if;
  logic valid;
  logic ready;
  logic gesture_done;
  logic click;
  logic hold;
  logic swipe_horizontal;
  logic swipe_vertical;
  logic vibrate;

  modport source (output valid, output gesture_done, output click, output hold,
                  output swipe_horizontal, output swipe_vertical, output vibrate,
                  input ready);
  modport sink (input valid, input gesture_done, input click, input hold,
                input swipe_horizontal, input swipe_vertical, input vibrate,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/tgc_cfg.sv =====
// ----------------------------------------------------------------------------
// Touch gesture classifier configuration registers
// Write-only register file; unknown indexes are dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tgc_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [tgc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [tgc_pkg::CFG_VAL_BITS-1:0]   cfg_wdata,
  output tgc_pkg::cfg_t                           cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wait_for_release <= tgc_pkg::RST_WAIT_FOR_RELEASE;
      cfg.swipe_threshold  <= tgc_pkg::RST_SWIPE_THRESHOLD;
      cfg.hold_ticks       <= tgc_pkg::RST_HOLD_TICKS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tgc_pkg::CFG_WAIT_FOR_RELEASE: cfg.wait_for_release <= cfg_wdata[0];
        tgc_pkg::CFG_SWIPE_THRESHOLD:
          cfg.swipe_threshold <= cfg_wdata[tgc_pkg::THRESH_BITS-1:0];
        tgc_pkg::CFG_HOLD_TICKS: cfg.hold_ticks <= cfg_wdata[tgc_pkg::HOLD_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tgc_core.sv =====
// ----------------------------------------------------------------------------
// Touch gesture classifier core
// Sample register, press tracking state and press, hold and release results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tgc_core (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire tgc_pkg::cfg_t cfg,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire tgc_pkg::sample_t in_sample,
  output logic           res_valid,
  output tgc_pkg::result_t res,
  input  wire logic      res_free
);

  logic               s1_valid;
  tgc_pkg::sample_t   s1;
  logic               tracking;
  logic               tracking_next;
  tgc_pkg::coord_t    start_x;
  tgc_pkg::coord_t    start_y;
  tgc_pkg::coord_t    last_x;
  tgc_pkg::coord_t    last_y;
  tgc_pkg::ticks_t    press_ticks;
  tgc_pkg::ticks_t    press_ticks_next;
  tgc_pkg::coord_t    dx;
  tgc_pkg::coord_t    dy;
  logic               sh;
  logic               sv;
  logic               swipe;
  logic               held;
  logic               has_res;
  logic               advance;
  tgc_pkg::ticks_t    hold_ext;

  assign hold_ext = tgc_pkg::TICK_BITS'(cfg.hold_ticks);
  assign dx = (start_x >= last_x) ? start_x - last_x : last_x - start_x;
  assign dy = (start_y >= last_y) ? start_y - last_y : last_y - start_y;
  assign sh = tgc_pkg::CMP_BITS'(dx) > tgc_pkg::CMP_BITS'(cfg.swipe_threshold);
  assign sv = tgc_pkg::CMP_BITS'(dy) > tgc_pkg::CMP_BITS'(cfg.swipe_threshold);
  assign swipe = sh | sv;
  assign held  = (press_ticks > hold_ext) && !swipe;

  always_comb begin
    has_res          = 1'b0;
    res              = '0;
    tracking_next    = tracking;
    press_ticks_next = press_ticks;
    if (!tracking) begin
      if (s1.touch_active) begin
        if (!cfg.wait_for_release) begin
          has_res          = 1'b1;
          res.gesture_done = 1'b1;
          res.click        = 1'b1;
          res.vibrate      = 1'b1;
        end else begin
          tracking_next    = 1'b1;
          press_ticks_next = '0;
        end
      end
    end else if (s1.touch_active) begin
      if (press_ticks == hold_ext) begin
        has_res     = 1'b1;
        res.vibrate = 1'b1;
      end
      if (press_ticks != tgc_pkg::TICKS_MAX) begin
        press_ticks_next = press_ticks + 1'b1;
      end
    end else begin
      has_res              = 1'b1;
      res.gesture_done     = 1'b1;
      res.hold             = held;
      res.swipe_horizontal = sh && !(swipe && dx < dy);
      res.swipe_vertical   = sv && !(swipe && dx > dy);
      res.click            = !swipe && !held;
      res.vibrate          = !swipe && !held;
      tracking_next        = 1'b0;
      press_ticks_next     = '0;
    end
  end

  assign advance   = s1_valid && (res_free || !has_res);
  assign in_ready  = !s1_valid || advance;
  assign res_valid = advance && has_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1 <= in_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tracking    <= 1'b0;
      press_ticks <= '0;
      start_x     <= '0;
      start_y     <= '0;
      last_x      <= '0;
      last_y      <= '0;
    end else if (advance) begin
      tracking    <= tracking_next;
      press_ticks <= press_ticks_next;
      if (s1.touch_active && (tracking || cfg.wait_for_release)) begin
        last_x <= s1.pos_x;
        last_y <= s1.pos_y;
      end
      if (s1.touch_active && !tracking && cfg.wait_for_release) begin
        start_x <= s1.pos_x;
        start_y <= s1.pos_y;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tgc_out_stage.sv =====
// ----------------------------------------------------------------------------
// Touch gesture classifier output register
// Holds one result until the sink takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tgc_out_stage (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       res_valid,
  input  wire tgc_pkg::result_t res,
  output logic            res_free,
  output logic            out_valid,
  output tgc_pkg::result_t out_res,
  input  wire logic       out_ready
);

  assign res_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_free) begin
      out_valid <= res_valid;
    end
    if (res_free && res_valid) begin
      out_res <= res;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/touch_gesture_classifier.sv =====
// ----------------------------------------------------------------------------
// Touch gesture classifier
// Turns touch-panel samples into click, hold, swipe and haptic requests.
// ----------------------------------------------------------------------------
// Takes one sample per clock cycle unless a result-bearing sample is waiting
// for the output register: a sample goes into an input register, is
// classified against the press state combinationally, and its result (if it
// gives one) lands in the output register. The output register alone sets the
// rate: while it holds an untaken result the next result-bearing sample
// waits, and in_ch.ready follows out_ch.ready combinationally. Samples that
// give no result (press start, ordinary held ticks, idle untouched ticks)
// pass without needing the output. Write configuration only while idle.
`timescale 1ns / 1ps
`default_nettype none

module touch_gesture_classifier (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [tgc_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [tgc_pkg::CFG_VAL_BITS-1:0] cfg_wdata,
  tgc_in_if.sink                                in_ch,
  tgc_out_if.source                             out_ch
);

  tgc_pkg::cfg_t    cfg;
  tgc_pkg::sample_t in_sample;
  tgc_pkg::result_t res;
  tgc_pkg::result_t out_res;
  logic             res_valid;
  logic             res_free;
  logic             in_ready;
  logic             out_valid;

  assign in_sample.touch_active = in_ch.touch_active;
  assign in_sample.pos_x        = in_ch.pos_x;
  assign in_sample.pos_y        = in_ch.pos_y;
  assign in_ch.ready            = in_ready;

  assign out_ch.valid            = out_valid;
  assign out_ch.gesture_done     = out_res.gesture_done;
  assign out_ch.click            = out_res.click;
  assign out_ch.hold             = out_res.hold;
  assign out_ch.swipe_horizontal = out_res.swipe_horizontal;
  assign out_ch.swipe_vertical   = out_res.swipe_vertical;
  assign out_ch.vibrate          = out_res.vibrate;

  tgc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tgc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .in_sample (in_sample),
    .res_valid (res_valid),
    .res       (res),
    .res_free  (res_free)
  );

  tgc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .res_free  (res_free),
    .out_valid (out_valid),
    .out_res   (out_res),
    .out_ready (out_ch.ready)
  );

endmodule

`default_nettype wire

// ===== rtl/tgc_checker.sv =====
// ----------------------------------------------------------------------------
// Touch gesture classifier checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "touch_gesture_classifier_defines.svh"

module tgc_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic gesture_done,
  input wire logic click,
  input wire logic hold,
  input wire logic swipe_horizontal,
  input wire logic swipe_vertical,
  input wire logic vibrate
);

  logic [5:0] payload;
  assign payload = {gesture_done, click, hold, swipe_horizontal, swipe_vertical, vibrate};

  `TGC_ASSERT_NOW(a_one_class, clk, rst, out_valid && gesture_done, $onehot({click, hold, swipe_horizontal || swipe_vertical}))
  `TGC_ASSERT_NOW(a_pulse_only, clk, rst, out_valid && !gesture_done, vibrate && !click && !hold && !swipe_horizontal && !swipe_vertical)
  `TGC_ASSERT_NOW(a_click_pulse, clk, rst, out_valid && gesture_done, click == vibrate)
  `TGC_ASSERT_NEXT(a_hold_stall, clk, rst, out_valid && !out_ready, out_valid && $stable(payload))

endmodule

bind touch_gesture_classifier tgc_checker u_tgc_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .gesture_done     (out_ch.gesture_done),
  .click            (out_ch.click),
  .hold             (out_ch.hold),
  .swipe_horizontal (out_ch.swipe_horizontal),
  .swipe_vertical   (out_ch.swipe_vertical),
  .vibrate          (out_ch.vibrate)
);

`default_nettype wire

// ===== dv/tb_touch_gesture_classifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch gesture classifier testbench
// Sends touch samples through the sample channel and predicts each click,
// hold, swipe and haptic request from a local model of the press state and
// the register settings. Results are compared field by field, in order.
// Directed presses and register extremes come first, then random gestures
// with random gaps and output stalls.
// ----------------------------------------------------------------------------

module tb_touch_gesture_classifier;
  import tgc_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;
  localparam int CLK_HALF     = 6;
  localparam int SETTLE       = 4;
  localparam int LIMIT_CYCLES = 400000;
  localparam int PHASE_ITEMS  = 60;

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_VAL_BITS-1:0] cfg_wdata;

  tgc_in_if  smp_ch ();
  tgc_out_if res_ch ();

  touch_gesture_classifier i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (smp_ch),
    .out_ch    (res_ch)
  );

  result_t gesture_q[$];
  result_t want_r;
  cfg_t    regs_now;
  logic    pressed;
  coord_t  org_x;
  coord_t  org_y;
  coord_t  cur_x;
  coord_t  cur_y;
  ticks_t  held;
  int      errors;
  int      cycles;
  int      items_sent;
  int      stall_left;
  bit      idle_en;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic classify(input sample_t s, output result_t r);
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic                  sh;
    logic                  sv;
    logic                  swiped;
    logic                  hl;
    logic                  pulse;
    r = '0;
    if (!pressed) begin
      if (!s.touch_active) return 1'b0;
      if (!regs_now.wait_for_release) begin
        r.gesture_done = 1'b1;
        r.click        = 1'b1;
        r.vibrate      = 1'b1;
        return 1'b1;
      end
      pressed = 1'b1;
      org_x   = s.pos_x;
      org_y   = s.pos_y;
      cur_x   = s.pos_x;
      cur_y   = s.pos_y;
      held    = '0;
      return 1'b0;
    end
    if (s.touch_active) begin
      pulse = (held == {1'b0, regs_now.hold_ticks});
      cur_x = s.pos_x;
      cur_y = s.pos_y;
      if (held != TICKS_MAX) held = held + 1'b1;
      r.vibrate = pulse;
      return pulse;
    end
    dx     = (org_x >= cur_x) ? org_x - cur_x : cur_x - org_x;
    dy     = (org_y >= cur_y) ? org_y - cur_y : cur_y - org_y;
    sh     = dx > regs_now.swipe_threshold;
    sv     = dy > regs_now.swipe_threshold;
    swiped = sh | sv;
    hl     = (held > {1'b0, regs_now.hold_ticks}) && !swiped;
    if (swiped) begin
      if (dx > dy) sv = 1'b0;
      if (dx < dy) sh = 1'b0;
    end
    r.gesture_done     = 1'b1;
    r.click            = !swiped && !hl;
    r.hold             = hl;
    r.swipe_horizontal = sh;
    r.swipe_vertical   = sv;
    r.vibrate          = !swiped && !hl;
    pressed = 1'b0;
    held    = '0;
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic want, input logic got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (gesture_q.size() == 0) begin
        $error("result with none expected");
        errors++;
      end else begin
        want_r = gesture_q.pop_front();
        check_field("gesture_done", want_r.gesture_done, res_ch.gesture_done);
        check_field("click", want_r.click, res_ch.click);
        check_field("hold", want_r.hold, res_ch.hold);
        check_field("swipe_horizontal", want_r.swipe_horizontal, res_ch.swipe_horizontal);
        check_field("swipe_vertical", want_r.swipe_vertical, res_ch.swipe_vertical);
        check_field("vibrate", want_r.vibrate, res_ch.vibrate);
      end
    end
  end

  always @(negedge clk) begin
    if (!idle_en) begin
      stall_left = 0;
      res_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      res_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 5);
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  task automatic send_sample(input logic act, input coord_t x, input coord_t y);
    sample_t s;
    result_t r;
    int      gap;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      smp_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    smp_ch.valid        <= 1'b1;
    smp_ch.touch_active <= act;
    smp_ch.pos_x        <= x;
    smp_ch.pos_y        <= y;
    do @(posedge clk); while (!smp_ch.ready);
    s = '{touch_active: act, pos_x: x, pos_y: y};
    if (classify(s, r)) gesture_q.push_back(r);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    smp_ch.valid <= 1'b0;
    while (gesture_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_VAL_BITS-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_WAIT_FOR_RELEASE: regs_now.wait_for_release = val[0];
      CFG_SWIPE_THRESHOLD:  regs_now.swipe_threshold  = val;
      CFG_HOLD_TICKS:       regs_now.hold_ticks       = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic gesture(input coord_t x0, input coord_t y0, input coord_t x1,
                         input coord_t y1, input int n);
    send_sample(1'b1, x0, y0);
    repeat (n) send_sample(1'b1, x1, y1);
    send_sample(1'b0, coord_t'($urandom), coord_t'($urandom));
  endtask

  function automatic coord_t near(input coord_t c, input int span);
    int v;
    v = int'(c);
    v = v + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return coord_t'(v);
  endfunction

  function automatic logic [CFG_VAL_BITS-1:0] pick_level();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      2:       return CFG_VAL_BITS'($urandom_range(0, 1023));
      default: return CFG_VAL_BITS'($urandom_range(0, 40));
    endcase
  endfunction

  task automatic test_immediate_clicks();
    write_reg(CFG_WAIT_FOR_RELEASE, 10'd0);
    send_sample(1'b1, 10'd0, 10'd0);
    send_sample(1'b1, 10'd1023, 10'd1023);
    send_sample(1'b0, 10'd1023, 10'd0);
    send_sample(1'b1, 10'h155, 10'h2aa);
    drain_results();
    write_reg(CFG_WAIT_FOR_RELEASE, 10'd1);
  endtask

  task automatic test_release_at_once();
    gesture(10'd0, 10'd0, 10'd0, 10'd0, 0);
    gesture(10'd1023, 10'd1023, 10'd0, 10'd0, 0);
  endtask

  task automatic test_swipes();
    gesture(10'd0, 10'd0, 10'd1023, 10'd0, 1);
    gesture(10'd0, 10'd0, 10'd0, 10'd1023, 1);
    gesture(10'd100, 10'd100, 10'd200, 10'd200, 1);
    gesture(10'd0, 10'd0, 10'd60, 10'd100, 1);
    gesture(10'd1023, 10'd500, 10'd972, 10'd500, 2);
  endtask

  task automatic test_hold_pulse();
    drain_results();
    write_reg(CFG_HOLD_TICKS, 10'd2);
    gesture(10'd10, 10'd10, 10'd12, 10'd12, 4);
    gesture(10'd10, 10'd10, 10'd500, 10'd10, 4);
    drain_results();
    write_reg(CFG_HOLD_TICKS, 10'd0);
    gesture(10'd0, 10'd0, 10'd0, 10'd0, 1);
    drain_results();
    write_reg(CFG_HOLD_TICKS, RST_HOLD_TICKS);
  endtask

  task automatic test_threshold_extremes();
    drain_results();
    write_reg(CFG_SWIPE_THRESHOLD, 10'd0);
    gesture(10'd5, 10'd5, 10'd6, 10'd5, 1);
    gesture(10'd5, 10'd5, 10'd5, 10'd5, 1);
    drain_results();
    write_reg(CFG_SWIPE_THRESHOLD, 10'd1023);
    gesture(10'd0, 10'd0, 10'd1023, 10'd1023, 1);
    drain_results();
    write_reg(CFG_SWIPE_THRESHOLD, RST_SWIPE_THRESHOLD);
  endtask

  task automatic test_mode_change_pressed();
    send_sample(1'b1, 10'd20, 10'd20);
    drain_results();
    write_reg(CFG_WAIT_FOR_RELEASE, 10'd0);
    send_sample(1'b1, 10'd300, 10'd20);
    send_sample(1'b0, 10'd0, 10'd0);
    send_sample(1'b1, 10'd7, 10'd7);
    drain_results();
    write_reg(CFG_WAIT_FOR_RELEASE, 10'd1);
  endtask

  task automatic test_unknown_index();
    write_reg(CFG_UNUSED, 10'd1023);
    gesture(10'd40, 10'd40, 10'd41, 10'd39, 1);
    drain_results();
  endtask

  task automatic test_long_press();
    idle_en = 1'b0;
    write_reg(CFG_HOLD_TICKS, 10'd100);
    write_reg(CFG_SWIPE_THRESHOLD, 10'd1023);
    gesture(10'd512, 10'd512, 10'd0, 10'd1023, 120);
    drain_results();
    idle_en = 1'b1;
  endtask

  task automatic rand_gesture();
    coord_t x0;
    coord_t y0;
    int     span;
    int     n;
    int     top;
    x0 = coord_t'($urandom);
    y0 = coord_t'($urandom);
    case ($urandom_range(0, 2))
      0:       span = 8;
      1:       span = 64;
      default: span = 600;
    endcase
    top = (regs_now.hold_ticks < 40) ? int'(regs_now.hold_ticks) + 3 : 40;
    n = $urandom_range(0, top);
    send_sample(1'b1, x0, y0);
    repeat (n) send_sample(1'b1, near(x0, span), near(y0, span));
    send_sample(1'b0, coord_t'($urandom), coord_t'($urandom));
  endtask

  task automatic test_random(input int phases);
    int target;
    for (int p = 0; p < phases; p++) begin
      drain_results();
      if (p == phases - 1) idle_en = 1'b0;
      write_reg(CFG_WAIT_FOR_RELEASE, (p == 2) ? 10'd0 : 10'($urandom_range(0, 4) != 0));
      write_reg(CFG_SWIPE_THRESHOLD, pick_level());
      write_reg(CFG_HOLD_TICKS, pick_level());
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        if ($urandom_range(0, 6) == 0)
          send_sample(1'($urandom), coord_t'($urandom), coord_t'($urandom));
        else
          rand_gesture();
      end
    end
    drain_results();
  endtask

  initial begin
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = CFG_WAIT_FOR_RELEASE;
    cfg_wdata           = '0;
    smp_ch.valid        = 1'b0;
    smp_ch.touch_active = 1'b0;
    smp_ch.pos_x        = '0;
    smp_ch.pos_y        = '0;
    res_ch.ready        = 1'b1;
    idle_en             = 1'b0;
    errors              = 0;
    cycles              = 0;
    items_sent          = 0;
    stall_left          = 0;
    regs_now = '{wait_for_release: RST_WAIT_FOR_RELEASE,
                 swipe_threshold: RST_SWIPE_THRESHOLD,
                 hold_ticks: RST_HOLD_TICKS};
    pressed = 1'b0;
    org_x   = '0;
    org_y   = '0;
    cur_x   = '0;
    cur_y   = '0;
    held    = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_immediate_clicks();
    idle_en = 1'b1;
    test_release_at_once();
    test_swipes();
    test_hold_pulse();
    test_threshold_extremes();
    test_mode_change_pressed();
    test_unknown_index();
    test_long_press();
    test_random(6);
    repeat (10) @(negedge clk);
    if (errors == 0 && gesture_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/tgc_pkg.sv
rtl/tgc_in_if.sv
rtl/tgc_out_if.sv
rtl/tgc_cfg.sv
rtl/tgc_core.sv
rtl/tgc_out_stage.sv
rtl/touch_gesture_classifier.sv
rtl/tgc_checker.sv
dv/tb_touch_gesture_classifier.sv
